>>> sv/esc_pkg.sv
// shared types and constants for the environmental sensor compensation core
package esc_pkg;

  localparam int WordW = 64;

  typedef logic [WordW-1:0] word_t;

  typedef enum logic [2:0] {
    CFG_TEMP       = 3'd0,
    CFG_PRESS_LOW  = 3'd1,
    CFG_PRESS_HIGH = 3'd2,
    CFG_PRESS_LAST = 3'd3,
    CFG_HUM        = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [31:0] temp;
    logic [31:0] fine;
    logic [16:0] hum;
    logic        hbad;
    logic        pbad;
  } side_t;

endpackage

>>> sv/esc_mul.sv
// two-stage 64 by 64 multiplier, product modulo 2^64, built from 32 by 32 partial products
module esc_mul (
  input  logic          clk_i,
  input  logic          en_i,
  input  esc_pkg::word_t a_i,
  input  esc_pkg::word_t b_i,
  output esc_pkg::word_t p_o
);

  logic [63:0] ll_q;
  logic [31:0] lh_q;
  logic [31:0] hl_q;
  logic [63:0] ll_d;
  logic [63:0] lh_d;
  logic [63:0] hl_d;
  esc_pkg::word_t p_q;

  assign ll_d = a_i[31:0] * b_i[31:0];
  assign lh_d = a_i[31:0] * b_i[63:32];
  assign hl_d = a_i[63:32] * b_i[31:0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ll_q <= ll_d;
      lh_q <= lh_d[31:0];
      hl_q <= hl_d[31:0];
      p_q  <= ll_q + {lh_q + hl_q, 32'b0};
    end
  end

  assign p_o = p_q;

endmodule

>>> sv/esc_div.sv
// pipelined signed 64-bit divider, one quotient bit per stage, truncating toward zero
module esc_div (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  esc_pkg::word_t  dividend_i,
  input  esc_pkg::word_t  divisor_i,
  input  esc_pkg::side_t  side_i,
  output logic            valid_o,
  output esc_pkg::word_t  quot_o,
  output esc_pkg::side_t  side_o
);

  localparam int Bits = esc_pkg::WordW;

  typedef struct packed {
    logic           v;
    logic           neg;
    logic [Bits:0]  rem;
    esc_pkg::word_t quo;
    esc_pkg::word_t den;
    esc_pkg::side_t side;
  } dstage_t;

  dstage_t st_q [Bits+1];
  dstage_t st0_d;
  logic           out_v_q;
  esc_pkg::word_t out_quot_q;
  esc_pkg::side_t out_side_q;

  always_comb begin
    st0_d      = '0;
    st0_d.v    = valid_i;
    st0_d.neg  = dividend_i[Bits-1] ^ divisor_i[Bits-1];
    st0_d.quo  = dividend_i[Bits-1] ? (Bits'(0) - dividend_i) : dividend_i;
    st0_d.den  = divisor_i[Bits-1] ? (Bits'(0) - divisor_i) : divisor_i;
    st0_d.side = side_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q[0] <= '0;
    end else if (en_i) begin
      st_q[0] <= st0_d;
    end
  end

  for (genvar k = 0; k < Bits; k++) begin : g_step
    dstage_t     nx_d;
    logic [Bits:0] sh;
    always_comb begin
      nx_d     = st_q[k];
      sh       = {st_q[k].rem[Bits-1:0], st_q[k].quo[Bits-1]};
      nx_d.quo = {st_q[k].quo[Bits-2:0], 1'b0};
      if (sh >= {1'b0, st_q[k].den}) begin
        nx_d.rem    = sh - {1'b0, st_q[k].den};
        nx_d.quo[0] = 1'b1;
      end else begin
        nx_d.rem = sh;
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        st_q[k+1] <= '0;
      end else if (en_i) begin
        st_q[k+1] <= nx_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en_i) begin
      out_v_q <= st_q[Bits].v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_quot_q <= st_q[Bits].neg ? (Bits'(0) - st_q[Bits].quo) : st_q[Bits].quo;
      out_side_q <= st_q[Bits].side;
    end
  end

  assign valid_o = out_v_q;
  assign quot_o  = out_quot_q;
  assign side_o  = out_side_q;

endmodule

>>> sv/environmental_sensor_compensation_core.sv
// top level of the temperature, pressure and humidity compensation pipeline
//
//   beat     dir  handshake                 payload
//   reading  in   in_valid_i / in_stall_o   raw_temperature_i, raw_pressure_i, raw_humidity_i
//   result   out  out_valid_o / out_stall_i temperature_centi_o ... humidity_invalid_o
//   config   in   cfg_we_i                  cfg_idx_i, cfg_wdata_i
//
// one reading per cycle, except while a result waits under out_stall_i
// the pipeline runs through the 64-stage divider and the chain of two-stage multipliers
// the whole pipeline holds while a result waits under out_stall_i
// reset clears valid bits and calibration registers to zero
module environmental_sensor_compensation_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [19:0]        raw_temperature_i,
  input  logic [19:0]        raw_pressure_i,
  input  logic [15:0]        raw_humidity_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] temperature_centi_o,
  output logic signed [31:0] fine_temperature_o,
  output logic [31:0]        pressure_q24_8_o,
  output logic               pressure_invalid_o,
  output logic [16:0]        humidity_q22_10_o,
  output logic               humidity_invalid_o,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [63:0]        cfg_wdata_i
);

  typedef logic [63:0] w_t;

  localparam w_t TempOff  = 64'd128000;
  localparam w_t PressRef = 64'd1048576;
  localparam w_t PressMul = 64'd3125;
  localparam w_t HumOff   = 64'd76800;
  localparam w_t HumRnd   = 64'd16384;
  localparam w_t HumAdd   = 64'd32768;
  localparam w_t HumBias  = 64'd2097152;
  localparam w_t HumRnd2  = 64'd8192;
  localparam w_t HumMax   = 64'd419430400;
  localparam logic [15:0] HumSkip = 16'h8000;

  typedef struct packed {
    logic v; logic [19:0] at; logic [19:0] ap; logic [15:0] ah;
  } s0_t;
  typedef struct packed {
    logic v; logic [19:0] ap; logic [15:0] ah; w_t ma;
  } c2_t;
  typedef struct packed {
    logic v; logic [19:0] ap; logic [15:0] ah; w_t fine;
  } sf_t;
  typedef struct packed {
    logic v; logic [19:0] ap; logic [15:0] ah; logic [31:0] fine; logic [31:0] temp;
    w_t a; w_t dt;
  } sg_t;
  typedef struct packed {
    logic v; logic [19:0] ap; logic [15:0] ah; logic [31:0] fine; logic [31:0] temp;
  } c4_t;
  typedef struct packed {
    logic v; logic [19:0] ap; logic [15:0] ah; logic [31:0] fine; logic [31:0] temp;
    w_t ap5; w_t ap2; w_t left;
  } c5_t;
  typedef struct packed {
    logic v; logic [19:0] ap; logic hbad; logic [31:0] fine; logic [31:0] temp;
    w_t left; w_t b;
  } c6_t;
  typedef struct packed {
    logic v; logic hbad; logic [31:0] fine; logic [31:0] temp; w_t av;
  } c7_t;
  typedef struct packed {
    logic v; logic hbad; logic [31:0] fine; logic [31:0] temp; w_t av; w_t n; w_t hv;
  } c8_t;
  typedef struct packed {
    logic v; w_t q; esc_pkg::side_t side;
  } ca_t;
  typedef struct packed {
    logic v; w_t q; esc_pkg::side_t side; w_t m2;
  } cb_t;

  logic en;
  logic [47:0] cal_t_q;
  logic [63:0] cal_pl_q;
  logic [63:0] cal_ph_q;
  logic [15:0] cal_p9_q;
  logic [63:0] cal_h_q;

  w_t t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9, h1, h2, h3, h4, h5, h6;

  s0_t s0_q, s0_d;
  s0_t c1_q [2];
  c2_t c2_q [2], c2_d;
  sf_t sf_q, sf_d;
  sg_t sg_q, sg_d;
  c4_t c4_q [2], c4_d;
  c5_t c5_q [2], c5_d;
  c6_t c6_q [2], c6_d;
  c7_t c7_q [2], c7_d;
  c8_t c8_q [2], c8_d;
  c8_t c9_q [2];
  ca_t ca_q [2], ca_d;
  cb_t cb_q [2], cb_d;

  w_t m1a, m1d, m2b, m_aa, m_ap5, m_ap2, m_h5dt, m_dh6, m_dh3;
  w_t m_aap6, m_aap3, m_in1, m_x, m_ih2, m_hv, m_n, m_vv, m_vh, m_p1, m_p2, m_p3;
  w_t x1, d1, fine5, hw, press;
  logic [16:0] hum;
  esc_pkg::side_t div_side_d;
  logic div_v;
  w_t div_q;
  esc_pkg::side_t div_side;

  logic        out_v_q;
  logic [31:0] out_temp_q, out_fine_q, out_press_q;
  logic        out_pbad_q, out_hbad_q;
  logic [16:0] out_hum_q;

  assign en         = !(out_v_q && out_stall_i);
  assign in_stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_t_q  <= '0;
      cal_pl_q <= '0;
      cal_ph_q <= '0;
      cal_p9_q <= '0;
      cal_h_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        esc_pkg::CFG_TEMP:       cal_t_q  <= cfg_wdata_i[47:0];
        esc_pkg::CFG_PRESS_LOW:  cal_pl_q <= cfg_wdata_i;
        esc_pkg::CFG_PRESS_HIGH: cal_ph_q <= cfg_wdata_i;
        esc_pkg::CFG_PRESS_LAST: cal_p9_q <= cfg_wdata_i[15:0];
        esc_pkg::CFG_HUM:        cal_h_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign t1 = {48'b0, cal_t_q[15:0]};
  assign t2 = {{48{cal_t_q[31]}}, cal_t_q[31:16]};
  assign t3 = {{48{cal_t_q[47]}}, cal_t_q[47:32]};
  assign p1 = {48'b0, cal_pl_q[15:0]};
  assign p2 = {{48{cal_pl_q[31]}}, cal_pl_q[31:16]};
  assign p3 = {{48{cal_pl_q[47]}}, cal_pl_q[47:32]};
  assign p4 = {{48{cal_pl_q[63]}}, cal_pl_q[63:48]};
  assign p5 = {{48{cal_ph_q[15]}}, cal_ph_q[15:0]};
  assign p6 = {{48{cal_ph_q[31]}}, cal_ph_q[31:16]};
  assign p7 = {{48{cal_ph_q[47]}}, cal_ph_q[47:32]};
  assign p8 = {{48{cal_ph_q[63]}}, cal_ph_q[63:48]};
  assign p9 = {{48{cal_p9_q[15]}}, cal_p9_q};
  assign h1 = {56'b0, cal_h_q[7:0]};
  assign h2 = {{48{cal_h_q[23]}}, cal_h_q[23:8]};
  assign h3 = {56'b0, cal_h_q[31:24]};
  assign h4 = {{52{cal_h_q[43]}}, cal_h_q[43:32]};
  assign h5 = {{52{cal_h_q[55]}}, cal_h_q[55:44]};
  assign h6 = {{56{cal_h_q[63]}}, cal_h_q[63:56]};

  // input register
  always_comb begin
    s0_d.v  = in_valid_i;
    s0_d.at = raw_temperature_i;
    s0_d.ap = raw_pressure_i;
    s0_d.ah = raw_humidity_i;
  end

  // temperature
  assign x1 = ({44'b0, s0_q.at} >> 3) - (t1 << 1);
  assign d1 = ({44'b0, s0_q.at} >> 4) - t1;

  esc_mul u_m1a (.clk_i, .en_i(en), .a_i(x1), .b_i(t2), .p_o(m1a));
  esc_mul u_m1d (.clk_i, .en_i(en), .a_i(d1), .b_i(d1), .p_o(m1d));

  always_comb begin
    c2_d.v  = c1_q[1].v;
    c2_d.ap = c1_q[1].ap;
    c2_d.ah = c1_q[1].ah;
    c2_d.ma = m1a;
  end

  esc_mul u_m2b (.clk_i, .en_i(en), .a_i(w_t'($signed(m1d) >>> 12)), .b_i(t3), .p_o(m2b));

  always_comb begin
    sf_d.v    = c2_q[1].v;
    sf_d.ap   = c2_q[1].ap;
    sf_d.ah   = c2_q[1].ah;
    sf_d.fine = w_t'($signed(c2_q[1].ma) >>> 11) + w_t'($signed(m2b) >>> 14);
  end

  assign fine5 = (sf_q.fine << 2) + sf_q.fine + 64'd128;

  always_comb begin
    sg_d.v    = sf_q.v;
    sg_d.ap   = sf_q.ap;
    sg_d.ah   = sf_q.ah;
    sg_d.fine = sf_q.fine[31:0];
    sg_d.temp = 32'(w_t'($signed(fine5) >>> 8));
    sg_d.a    = sf_q.fine - TempOff;
    sg_d.dt   = sf_q.fine - HumOff;
  end

  // first products of pressure and humidity
  esc_mul u_aa   (.clk_i, .en_i(en), .a_i(sg_q.a),  .b_i(sg_q.a), .p_o(m_aa));
  esc_mul u_ap5  (.clk_i, .en_i(en), .a_i(sg_q.a),  .b_i(p5),     .p_o(m_ap5));
  esc_mul u_ap2  (.clk_i, .en_i(en), .a_i(sg_q.a),  .b_i(p2),     .p_o(m_ap2));
  esc_mul u_h5dt (.clk_i, .en_i(en), .a_i(h5),      .b_i(sg_q.dt), .p_o(m_h5dt));
  esc_mul u_dh6  (.clk_i, .en_i(en), .a_i(sg_q.dt), .b_i(h6),     .p_o(m_dh6));
  esc_mul u_dh3  (.clk_i, .en_i(en), .a_i(sg_q.dt), .b_i(h3),     .p_o(m_dh3));

  always_comb begin
    c4_d.v    = sg_q.v;
    c4_d.ap   = sg_q.ap;
    c4_d.ah   = sg_q.ah;
    c4_d.fine = sg_q.fine;
    c4_d.temp = sg_q.temp;
  end

  esc_mul u_aap6 (.clk_i, .en_i(en), .a_i(m_aa), .b_i(p6), .p_o(m_aap6));
  esc_mul u_aap3 (.clk_i, .en_i(en), .a_i(m_aa), .b_i(p3), .p_o(m_aap3));
  esc_mul u_in1 (
    .clk_i, .en_i(en),
    .a_i(w_t'($signed(m_dh6) >>> 10)),
    .b_i(w_t'($signed(m_dh3) >>> 11) + HumAdd),
    .p_o(m_in1)
  );

  always_comb begin
    c5_d.v    = c4_q[1].v;
    c5_d.ap   = c4_q[1].ap;
    c5_d.ah   = c4_q[1].ah;
    c5_d.fine = c4_q[1].fine;
    c5_d.temp = c4_q[1].temp;
    c5_d.ap5  = m_ap5;
    c5_d.ap2  = m_ap2;
    c5_d.left = w_t'($signed(({48'b0, c4_q[1].ah} << 14) - (h4 << 20) - m_h5dt + HumRnd)
                >>> 15);
  end

  esc_mul u_x (
    .clk_i, .en_i(en),
    .a_i((64'd1 << 47) + w_t'($signed(m_aap3) >>> 8) + (c5_q[1].ap2 << 12)),
    .b_i(p1),
    .p_o(m_x)
  );
  esc_mul u_ih2 (
    .clk_i, .en_i(en),
    .a_i(w_t'($signed(m_in1) >>> 10) + HumBias),
    .b_i(h2),
    .p_o(m_ih2)
  );

  always_comb begin
    c6_d.v    = c5_q[1].v;
    c6_d.ap   = c5_q[1].ap;
    c6_d.hbad = (c5_q[1].ah == HumSkip);
    c6_d.fine = c5_q[1].fine;
    c6_d.temp = c5_q[1].temp;
    c6_d.left = c5_q[1].left;
    c6_d.b    = m_aap6 + (c5_q[1].ap5 << 17) + (p4 << 35);
  end

  esc_mul u_hv (
    .clk_i, .en_i(en),
    .a_i(c6_q[1].left),
    .b_i(w_t'($signed(m_ih2 + HumRnd2) >>> 14)),
    .p_o(m_hv)
  );
  esc_mul u_n (
    .clk_i, .en_i(en),
    .a_i(((PressRef - {44'b0, c6_q[1].ap}) << 31) - c6_q[1].b),
    .b_i(PressMul),
    .p_o(m_n)
  );

  always_comb begin
    c7_d.v    = c6_q[1].v;
    c7_d.hbad = c6_q[1].hbad;
    c7_d.fine = c6_q[1].fine;
    c7_d.temp = c6_q[1].temp;
    c7_d.av   = w_t'($signed(m_x) >>> 33);
  end

  esc_mul u_vv (
    .clk_i, .en_i(en),
    .a_i(w_t'($signed(m_hv) >>> 15)),
    .b_i(w_t'($signed(m_hv) >>> 15)),
    .p_o(m_vv)
  );

  always_comb begin
    c8_d.v    = c7_q[1].v;
    c8_d.hbad = c7_q[1].hbad;
    c8_d.fine = c7_q[1].fine;
    c8_d.temp = c7_q[1].temp;
    c8_d.av   = c7_q[1].av;
    c8_d.n    = m_n;
    c8_d.hv   = m_hv;
  end

  esc_mul u_vh (
    .clk_i, .en_i(en), .a_i(w_t'($signed(m_vv) >>> 7)), .b_i(h1), .p_o(m_vh)
  );

  // humidity finish and clamp
  always_comb begin
    hw = c9_q[1].hv - w_t'($signed(m_vh) >>> 4);
    if (hw[63]) begin
      hw = '0;
    end else if (hw > HumMax) begin
      hw = HumMax;
    end
    hum = c9_q[1].hbad ? 17'd0 : hw[28:12];
    div_side_d.temp = c9_q[1].temp;
    div_side_d.fine = c9_q[1].fine;
    div_side_d.hum  = hum;
    div_side_d.hbad = c9_q[1].hbad;
    div_side_d.pbad = (c9_q[1].av == '0);
  end

  esc_div u_div (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(c9_q[1].v),
    .dividend_i(c9_q[1].n),
    .divisor_i(c9_q[1].av),
    .side_i(div_side_d),
    .valid_o(div_v),
    .quot_o(div_q),
    .side_o(div_side)
  );

  // pressure correction terms
  esc_mul u_p1 (.clk_i, .en_i(en), .a_i(p9), .b_i(w_t'($signed(div_q) >>> 13)), .p_o(m_p1));
  esc_mul u_p2 (.clk_i, .en_i(en), .a_i(p8), .b_i(div_q), .p_o(m_p2));

  always_comb begin
    ca_d.v    = div_v;
    ca_d.q    = div_q;
    ca_d.side = div_side;
  end

  esc_mul u_p3 (
    .clk_i, .en_i(en), .a_i(m_p1), .b_i(w_t'($signed(ca_q[1].q) >>> 13)), .p_o(m_p3)
  );

  always_comb begin
    cb_d.v    = ca_q[1].v;
    cb_d.q    = ca_q[1].q;
    cb_d.side = ca_q[1].side;
    cb_d.m2   = m_p2;
  end

  assign press = w_t'($signed(cb_q[1].q + w_t'($signed(m_p3) >>> 25)
                 + w_t'($signed(cb_q[1].m2) >>> 19)) >>> 8) + (p7 << 4);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_q  <= '0;
      c1_q  <= '{default: '0};
      c2_q  <= '{default: '0};
      sf_q  <= '0;
      sg_q  <= '0;
      c4_q  <= '{default: '0};
      c5_q  <= '{default: '0};
      c6_q  <= '{default: '0};
      c7_q  <= '{default: '0};
      c8_q  <= '{default: '0};
      c9_q  <= '{default: '0};
      ca_q  <= '{default: '0};
      cb_q  <= '{default: '0};
      out_v_q <= 1'b0;
    end else if (en) begin
      s0_q    <= s0_d;
      c1_q[0] <= s0_q;
      c1_q[1] <= c1_q[0];
      c2_q[0] <= c2_d;
      c2_q[1] <= c2_q[0];
      sf_q    <= sf_d;
      sg_q    <= sg_d;
      c4_q[0] <= c4_d;
      c4_q[1] <= c4_q[0];
      c5_q[0] <= c5_d;
      c5_q[1] <= c5_q[0];
      c6_q[0] <= c6_d;
      c6_q[1] <= c6_q[0];
      c7_q[0] <= c7_d;
      c7_q[1] <= c7_q[0];
      c8_q[0] <= c8_d;
      c8_q[1] <= c8_q[0];
      c9_q[0] <= c8_q[1];
      c9_q[1] <= c9_q[0];
      ca_q[0] <= ca_d;
      ca_q[1] <= ca_q[0];
      cb_q[0] <= cb_d;
      cb_q[1] <= cb_q[0];
      out_v_q <= cb_q[1].v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_temp_q  <= cb_q[1].side.temp;
      out_fine_q  <= cb_q[1].side.fine;
      out_press_q <= cb_q[1].side.pbad ? 32'd0 : press[31:0];
      out_pbad_q  <= cb_q[1].side.pbad;
      out_hum_q   <= cb_q[1].side.hum;
      out_hbad_q  <= cb_q[1].side.hbad;
    end
  end

  assign out_valid_o         = out_v_q;
  assign temperature_centi_o = $signed(out_temp_q);
  assign fine_temperature_o  = $signed(out_fine_q);
  assign pressure_q24_8_o    = out_press_q;
  assign pressure_invalid_o  = out_pbad_q;
  assign humidity_q22_10_o   = out_hum_q;
  assign humidity_invalid_o  = out_hbad_q;

endmodule

>>> sim/environmental_sensor_compensation_core_test.sv
// self-checking testbench for the environmental sensor compensation core
`timescale 1ns / 100ps

module environmental_sensor_compensation_core_test;

  typedef struct {
    logic [31:0] temp;
    logic [31:0] fine;
    logic [31:0] press;
    logic        pbad;
    logic [16:0] hum;
    logic        hbad;
  } reading_result_t;

  class compensation_scoreboard;
    logic [63:0] cal_regs [5];
    reading_result_t pending_q[$];
    int errors;
    int checked;

    function new();
      foreach (cal_regs[i]) cal_regs[i] = '0;
      errors = 0;
      checked = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [63:0] val);
      case (idx)
        esc_pkg::CFG_TEMP:       cal_regs[idx] = val & 64'hFFFF_FFFF_FFFF;
        esc_pkg::CFG_PRESS_LOW, esc_pkg::CFG_PRESS_HIGH, esc_pkg::CFG_HUM:
          cal_regs[idx] = val;
        esc_pkg::CFG_PRESS_LAST: cal_regs[idx] = val & 64'hFFFF;
        default: ;
      endcase
    endfunction

    function reading_result_t compensate(logic [19:0] rt, logic [19:0] rp,
                                         logic [15:0] rh);
      reading_result_t r;
      longint t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
      longint h1, h2, h3, h4, h5, h6;
      longint a, b, d, fine, p, dt, lft, inner, rgt, v;
      t1 = longint'({48'd0, cal_regs[esc_pkg::CFG_TEMP][15:0]});
      t2 = longint'($signed(cal_regs[esc_pkg::CFG_TEMP][31:16]));
      t3 = longint'($signed(cal_regs[esc_pkg::CFG_TEMP][47:32]));
      p1 = longint'({48'd0, cal_regs[esc_pkg::CFG_PRESS_LOW][15:0]});
      p2 = longint'($signed(cal_regs[esc_pkg::CFG_PRESS_LOW][31:16]));
      p3 = longint'($signed(cal_regs[esc_pkg::CFG_PRESS_LOW][47:32]));
      p4 = longint'($signed(cal_regs[esc_pkg::CFG_PRESS_LOW][63:48]));
      p5 = longint'($signed(cal_regs[esc_pkg::CFG_PRESS_HIGH][15:0]));
      p6 = longint'($signed(cal_regs[esc_pkg::CFG_PRESS_HIGH][31:16]));
      p7 = longint'($signed(cal_regs[esc_pkg::CFG_PRESS_HIGH][47:32]));
      p8 = longint'($signed(cal_regs[esc_pkg::CFG_PRESS_HIGH][63:48]));
      p9 = longint'($signed(cal_regs[esc_pkg::CFG_PRESS_LAST][15:0]));
      h1 = longint'({56'd0, cal_regs[esc_pkg::CFG_HUM][7:0]});
      h2 = longint'($signed(cal_regs[esc_pkg::CFG_HUM][23:8]));
      h3 = longint'({56'd0, cal_regs[esc_pkg::CFG_HUM][31:24]});
      h4 = longint'($signed(cal_regs[esc_pkg::CFG_HUM][43:32]));
      h5 = longint'($signed(cal_regs[esc_pkg::CFG_HUM][55:44]));
      h6 = longint'($signed(cal_regs[esc_pkg::CFG_HUM][63:56]));

      a = ((longint'(rt >> 3) - (t1 <<< 1)) * t2) >>> 11;
      d = longint'(rt >> 4) - t1;
      b = (((d * d) >>> 12) * t3) >>> 14;
      fine = a + b;
      r.temp = 32'((fine * 5 + 128) >>> 8);
      r.fine = 32'(fine);

      a = fine - 128000;
      b = a * a * p6;
      b = b + ((a * p5) <<< 17);
      b = b + (p4 <<< 35);
      a = ((a * a * p3) >>> 8) + ((a * p2) <<< 12);
      a = (((64'sd1 <<< 47) + a) * p1) >>> 33;
      r.press = '0;
      r.pbad = 1'b0;
      if (a == 0) begin
        r.pbad = 1'b1;
      end else begin
        p = 1048576 - longint'(rp);
        p = (((p <<< 31) - b) * 3125) / a;
        v = (p9 * (p >>> 13) * (p >>> 13)) >>> 25;
        d = (p8 * p) >>> 19;
        p = ((p + v + d) >>> 8) + (p7 <<< 4);
        r.press = 32'(p);
      end

      r.hum = '0;
      r.hbad = 1'b0;
      if (rh == 16'h8000) begin
        r.hbad = 1'b1;
      end else begin
        dt = fine - 76800;
        lft = ((longint'(rh) <<< 14) - (h4 <<< 20) - h5 * dt + 16384) >>> 15;
        inner = ((((dt * h6) >>> 10) * (((dt * h3) >>> 11) + 32768)) >>> 10) + 2097152;
        rgt = (inner * h2 + 8192) >>> 14;
        v = lft * rgt;
        v = v - (((((v >>> 15) * (v >>> 15)) >>> 7) * h1) >>> 4);
        if (v < 0) v = 0;
        if (v > 419430400) v = 419430400;
        r.hum = 17'(v >>> 12);
      end
      return r;
    endfunction

    function void note_reading(logic [19:0] rt, logic [19:0] rp, logic [15:0] rh);
      pending_q.push_back(compensate(rt, rp, rh));
    endfunction

    task report_mismatch(string what, longint got, longint want);
      errors++;
      if (errors <= 40)
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    endtask

    task check_result(reading_result_t got);
      reading_result_t want;
      if (pending_q.size() == 0) begin
        report_mismatch("result beat with nothing pending", 0, 0);
        return;
      end
      want = pending_q.pop_front();
      checked++;
      if (got.temp !== want.temp) report_mismatch("temperature_centi", got.temp, want.temp);
      if (got.fine !== want.fine) report_mismatch("fine_temperature", got.fine, want.fine);
      if (got.press !== want.press) report_mismatch("pressure_q24_8", got.press, want.press);
      if (got.pbad !== want.pbad) report_mismatch("pressure_invalid", got.pbad, want.pbad);
      if (got.hum !== want.hum) report_mismatch("humidity_q22_10", got.hum, want.hum);
      if (got.hbad !== want.hbad) report_mismatch("humidity_invalid", got.hbad, want.hbad);
    endtask
  endclass

  localparam int Latency = 89;
  localparam int WatchdogLimit = 4000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [19:0] raw_temperature_i = '0;
  logic [19:0] raw_pressure_i = '0;
  logic [15:0] raw_humidity_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [31:0] temperature_centi_o;
  logic signed [31:0] fine_temperature_o;
  logic [31:0] pressure_q24_8_o;
  logic pressure_invalid_o;
  logic [16:0] humidity_q22_10_o;
  logic humidity_invalid_o;
  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_idx_i = '0;
  logic [63:0] cfg_wdata_i = '0;

  compensation_scoreboard sb = new();
  int idle_cycles = 0;
  int sent = 0;
  bit stall_random = 1'b1;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  environmental_sensor_compensation_core DUT (.*);

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      reading_result_t got;
      got.temp = temperature_centi_o;
      got.fine = fine_temperature_o;
      got.press = pressure_q24_8_o;
      got.pbad = pressure_invalid_o;
      got.hum = humidity_q22_10_o;
      got.hbad = humidity_invalid_o;
      sb.check_result(got);
    end
  end

  // receiver: random stall lengths per beat, sometimes none; no stalls while stall_random is clear
  initial begin : receiver
    int w;
    @(posedge rst_ni);
    forever begin
      w = stall_random ? (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11)) : 0;
      if (w > 0) begin
        out_stall_i <= 1'b1;
        repeat (w) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || !rst_ni)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("watchdog expired with %0d results pending", sb.pending_q.size());
      $display("FAIL environmental_sensor_compensation_core");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    sb.set_reg(idx, val);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_reading(logic [19:0] rt, logic [19:0] rp, logic [15:0] rh,
                              bit gaps);
    int w;
    w = gaps ? (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11)) : 0;
    if (w > 0) begin
      in_valid_i <= 1'b0;
      repeat (w) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    raw_temperature_i <= rt;
    raw_pressure_i <= rp;
    raw_humidity_i <= rh;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_reading(rt, rp, rh);
    sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (Latency + 10) @(posedge clk_i);
  endtask

  // calibration sets near those of a real part
  task automatic load_typical();
    write_reg(esc_pkg::CFG_TEMP, {16'sd50, 16'sd26435, 16'd27504});
    write_reg(esc_pkg::CFG_PRESS_LOW, {16'sd2855, 16'sd3024, -16'sd10685, 16'd36477});
    write_reg(esc_pkg::CFG_PRESS_HIGH, {-16'sd12000, 16'sd15500, -16'sd7, 16'sd140});
    write_reg(esc_pkg::CFG_PRESS_LAST, 64'(16'sd6000));
    write_reg(esc_pkg::CFG_HUM, {8'sd30, 12'sd50, 12'sd312, 8'd0, 16'sd363, 8'd75});
  endtask

  task automatic random_phase(int n, bit typical);
    logic [19:0] rt, rp;
    logic [15:0] rh;
    for (int i = 0; i < n; i++) begin
      if (typical) begin
        rt = 20'($urandom_range(400000, 600000));
        rp = 20'($urandom_range(250000, 450000));
        rh = 16'($urandom_range(20000, 40000));
      end else begin
        rt = 20'($urandom);
        rp = 20'($urandom);
        rh = 16'($urandom);
      end
      if ($urandom_range(0, 19) == 0) rh = 16'h8000;
      send_reading(rt, rp, rh, i % 60 < 45);
    end
  endtask

  initial begin : stimulus
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // zero calibration: pressure divisor zero
    send_reading(20'd0, 20'd0, 16'd0, 0);
    send_reading(20'hFFFFF, 20'hFFFFF, 16'hFFFF, 0);
    send_reading(20'h80000, 20'h12345, 16'h8000, 0);
    drain();

    load_typical();
    write_reg(3'd7, 64'hFFFF_FFFF_FFFF_FFFF);
    send_reading(20'd519888, 20'd415148, 16'd30000, 0);
    send_reading(20'd0, 20'd0, 16'd0, 0);
    send_reading(20'hFFFFF, 20'hFFFFF, 16'hFFFF, 0);
    send_reading(20'd0, 20'hFFFFF, 16'h8000, 0);
    send_reading(20'hFFFFF, 20'd0, 16'h7FFF, 0);
    send_reading(20'h55555, 20'hAAAAA, 16'h5555, 0);
    send_reading(20'hAAAAA, 20'h55555, 16'hAAAA, 0);
    send_reading(20'd519888, 20'd415148, 16'h8001, 0);
    send_reading(20'd519888, 20'd100, 16'd60000, 0);
    random_phase(160, 1);
    drain();

    // extreme calibration words
    write_reg(esc_pkg::CFG_TEMP, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(esc_pkg::CFG_PRESS_LOW, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(esc_pkg::CFG_PRESS_HIGH, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(esc_pkg::CFG_PRESS_LAST, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(esc_pkg::CFG_HUM, 64'hFFFF_FFFF_FFFF_FFFF);
    send_reading(20'd0, 20'd0, 16'd0, 0);
    send_reading(20'hFFFFF, 20'hFFFFF, 16'hFFFF, 0);
    random_phase(40, 0);
    drain();

    write_reg(esc_pkg::CFG_TEMP, {16'h8000, 16'h8000, 16'h0000});
    write_reg(esc_pkg::CFG_PRESS_LOW, {16'h7FFF, 16'h8000, 16'h7FFF, 16'hFFFF});
    write_reg(esc_pkg::CFG_PRESS_HIGH, {16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF});
    write_reg(esc_pkg::CFG_PRESS_LAST, 64'h8000);
    write_reg(esc_pkg::CFG_HUM, 64'h7F80_07FF_FF7F_FFFF);
    random_phase(40, 0);
    drain();

    // fully random calibration, with and without receiver stalls
    for (int k = 0; k < 4; k++) begin
      stall_random = (k != 2);
      for (int r = 0; r < 5; r++) write_reg(3'(r), {$urandom, $urandom});
      random_phase(50, k[0]);
      drain();
    end
    stall_random = 1'b1;

    load_typical();
    random_phase(20, 1);
    drain();

    $display("%0d readings sent, %0d results checked over zero, typical, extreme and",
             sent, sb.checked);
    $display("random calibration sets with random gaps on both sides");
    if (sb.errors == 0) begin
      $display("PASS environmental_sensor_compensation_core");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("FAIL environmental_sensor_compensation_core");
    end
    $finish;
  end
endmodule
